### hdl/b64_pkg.sv
`timescale 1ns / 1ps

package b64_pkg;

	localparam int unsigned QueueDepth = 2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] code_char;
		logic       end_of_message;
	} out_word_t;

	typedef enum logic [1:0] {
		PH0 = 2'd0,
		PH1 = 2'd1,
		PH2 = 2'd2
	} phase_t;

	// up to four characters produced by one byte; last_idx is count minus one
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            fin;
	} job_t;

	function automatic logic [7:0] sym(input logic [5:0] six);
		logic [7:0] v;
		v = {2'b00, six};
		if (six < 6'd26) begin
			return 8'h41 + v;
		end else if (six < 6'd52) begin
			return 8'h61 + (v - 8'd26);
		end else if (six < 6'd62) begin
			return 8'h30 + (v - 8'd52);
		end else if (six == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

endpackage

### hdl/base64_stream_encoder.sv
`timescale 1ns / 1ps

// Base64 stream encoder (standard alphabet, '=' padding). Bytes enter on the byte
// channel, one word each, final_byte marking the last byte of a message; characters
// leave on the char channel one per cycle while char_stall is low, end_of_message on
// the last one. A byte is taken whenever the job queue has room, and it yields one to
// four characters; the output register drains one character per cycle unless
// char_stall holds it, so the sustained rate is set by that single output port, with
// a byte accepted every cycle until the queue (QUEUE_DEPTH jobs) fills.
module base64_stream_encoder import b64_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_word_t  byte_word,
	output logic      char_valid,
	input  logic      char_stall,
	output out_word_t char_word
);

	job_t new_job, head_job;
	logic take, pop, full, empty;

	assign byte_stall = full;
	assign take       = byte_valid && !full;

	b64_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (byte_word),
		.job    (new_job)
	);

	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.push_job (new_job),
		.pop      (pop),
		.head     (head_job),
		.full     (full),
		.empty    (empty)
	);

	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_job),
		.empty     (empty),
		.pop       (pop),
		.out_valid (char_valid),
		.out_stall (char_stall),
		.out_word  (char_word)
	);

endmodule

### hdl/b64_front.sv
`timescale 1ns / 1ps

module b64_front import b64_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  in_word_t word,
	output job_t     job
);

	phase_t     phase_q, phase_d;
	logic [3:0] left_q, left_d;
	logic [7:0] b;
	logic       fin;

	assign b   = word.data_byte;
	assign fin = word.final_byte;

	always_comb begin
		job.chars    = {4{PAD_CHAR}};
		job.last_idx = 2'd0;
		job.fin      = fin;
		phase_d      = phase_q;
		left_d       = left_q;
		case (phase_q)
			PH1: begin
				job.chars[0] = sym({left_q[1:0], b[7:4]});
				job.chars[1] = sym({b[3:0], 2'b00});
				job.last_idx = fin ? 2'd2 : 2'd0;
				phase_d      = fin ? PH0 : PH2;
				left_d       = fin ? 4'd0 : b[3:0];
			end
			PH2: begin
				job.chars[0] = sym({left_q, b[7:6]});
				job.chars[1] = sym(b[5:0]);
				job.last_idx = 2'd1;
				phase_d      = PH0;
				left_d       = 4'd0;
			end
			default: begin
				// unused phase code behaves as phase 0
				job.chars[0] = sym(b[7:2]);
				job.chars[1] = sym({b[1:0], 4'b0000});
				job.last_idx = fin ? 2'd3 : 2'd0;
				phase_d      = fin ? PH0 : PH1;
				left_d       = fin ? 4'd0 : {2'b00, b[1:0]};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH0;
			left_q  <= 4'd0;
		end else if (take) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

### hdl/b64_queue.sv
`timescale 1ns / 1ps

module b64_queue import b64_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic full,
	output logic empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full)
		else $error("push into full queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance");
`endif

endmodule

### hdl/b64_back.sv
`timescale 1ns / 1ps

module b64_back import b64_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  logic      empty,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	logic [1:0] idx_q;
	logic       valid_q;
	out_word_t  word_q;
	logic       advance, load, at_last;

	assign advance = !valid_q || !out_stall;
	assign load    = advance && !empty;
	assign at_last = (idx_q == head.last_idx);
	assign pop     = load && at_last;

	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (advance) begin
			valid_q <= !empty;
			if (load) begin
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q.code_char      <= head.chars[idx_q];
			word_q.end_of_message <= head.fin && at_last;
		end
	end

endmodule
